@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the loader rtl
// expects clk and arst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked while out of reset
`define GCL_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define GCL_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GCL_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/gcl_pkg.sv @@
// package for the greedy capacity loader
// types, widths and codes used by all loader modules; no dependencies
`timescale 1ns / 1ps

package gcl_pkg;

	localparam int GCL_MAX_ITEMS = 32;
	localparam int WEIGHT_W      = 24;
	localparam int SUM_W         = 32;
	localparam int CAP_W         = 16;
	localparam int FRAC_W        = 8;
	localparam int CFG_IDX_W     = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CAPACITY = 1'b0;
	localparam cfg_idx_t CFG_MODE     = 1'b1;

	localparam logic MODE_COUNT  = 1'b0;
	localparam logic MODE_WEIGHT = 1'b1;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                last_item;
	} item_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] chosen_weight;
		logic                end_of_run;
		logic                none_chosen;
	} result_t;

	typedef enum logic {
		CMP_LESS,
		CMP_GREATER
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t          op;
		logic             add_en;
		logic [SUM_W-1:0] x;
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] r;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             hit;
	} alu_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TEST,
		ST_FINISH
	} seq_state_t;

endpackage

@@ rtl/core/greedy_capacity_loader.sv @@
// top level of the greedy capacity loader: configuration registers and wiring
// depends on gcl_pkg, gcl_store, gcl_alu, gcl_seq
//
// Usage: present a request on item with start high; it is taken at a clock edge
// where busy is low, with no gap needed between requests. Each request stores one
// weight (weights beyond MAX_ITEMS are dropped). A request with last_item set
// closes the set and starts selection; busy stays high until it finishes.
// Selection is a selection sort over the weight memory: each round reads the n
// stored weights through the single read port, whose data is registered, and
// then runs one fit test through the shared add/compare unit. At most n rounds
// run, followed by one closing state before the block returns to idle.
// Results appear on result for exactly one cycle each, marked by result_valid;
// the receiver cannot stall them. The last one carries end_of_run, and an empty
// selection gives one result with none_chosen set.
// Configuration goes through cfg_valid/cfg_ready (always ready) with cfg_index
// 0 = capacity, 1 = mode; write it only while the block is idle.
// Reset (arst_n low) clears the set, the running sum and both registers; the
// weight memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module greedy_capacity_loader import gcl_pkg::*; #(
	parameter int MAX_ITEMS = GCL_MAX_ITEMS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  item_t            item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [CAP_W-1:0] cfg_data,
	output result_t          result,
	output logic             result_valid
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic [CAP_W-1:0] capacity_q;
	logic             mode_q;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [WEIGHT_W-1:0] mem_wdata;
	logic                mem_re;
	logic [IDX_W-1:0]    mem_raddr;
	logic [WEIGHT_W-1:0] mem_rdata;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			mode_q     <= MODE_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_data;
				CFG_MODE:     mode_q     <= cfg_data[0];
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	gcl_store #(
		.DEPTH  (MAX_ITEMS),
		.ADDR_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gcl_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	gcl_seq #(
		.MAX_ITEMS (MAX_ITEMS),
		.CNT_W     (CNT_W),
		.IDX_W     (IDX_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.capacity     (capacity_q),
		.mode         (mode_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.alu_req      (alu_req),
		.alu_rsp      (alu_rsp),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

@@ rtl/core/gcl_store.sv @@
// weight memory: one write port, one read port with registered data
// depends on gcl_pkg
`timescale 1ns / 1ps

module gcl_store import gcl_pkg::*; #(
	parameter int DEPTH  = GCL_MAX_ITEMS,
	parameter int ADDR_W = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  logic [WEIGHT_W-1:0] wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output logic [WEIGHT_W-1:0] rdata
);

	logic [WEIGHT_W-1:0] mem_q [DEPTH];
	logic [WEIGHT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/gcl_alu.sv @@
// shared add and compare unit used for both the sort scan and the fit test
// depends on gcl_pkg
`timescale 1ns / 1ps

module gcl_alu import gcl_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [SUM_W-1:0] sum;

	always_comb begin
		sum     = req.x + (req.add_en ? req.s : '0);
		rsp.sum = sum;
		case (req.op)
			CMP_LESS:    rsp.hit = sum < req.r;
			CMP_GREATER: rsp.hit = req.r < sum;
			default:     rsp.hit = 1'b0;
		endcase
	end

endmodule

@@ rtl/core/gcl_seq.sv @@
// sequencer: loads weights, runs selection-sort scans and the greedy fit test
// depends on gcl_pkg, assert_macros.svh; drives gcl_store and gcl_alu
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gcl_seq import gcl_pkg::*; #(
	parameter int MAX_ITEMS = GCL_MAX_ITEMS,
	parameter int CNT_W     = $clog2(MAX_ITEMS + 1),
	parameter int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  item_t               item,
	input  logic [CAP_W-1:0]    capacity,
	input  logic                mode,
	output logic                mem_we,
	output logic [IDX_W-1:0]    mem_waddr,
	output logic [WEIGHT_W-1:0] mem_wdata,
	output logic                mem_re,
	output logic [IDX_W-1:0]    mem_raddr,
	input  logic [WEIGHT_W-1:0] mem_rdata,
	output alu_req_t            alu_req,
	input  alu_rsp_t            alu_rsp,
	output result_t             result,
	output logic                result_valid
);

	seq_state_t state_q, state_d;

	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     issue_cnt_q;
	logic [CNT_W-1:0]     rounds_q;
	logic [SUM_W-1:0]     sum_q;
	logic [MAX_ITEMS-1:0] taken_q;
	logic                 found_q;
	logic                 have_pend_q;
	logic                 rd_valid_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [WEIGHT_W-1:0]  best_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [WEIGHT_W-1:0]  pend_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic             store_room;
	logic [IDX_W-1:0] last_idx;
	logic             final_round;
	logic             accept;
	logic             better;

	assign store_room  = cnt_q < CNT_W'(MAX_ITEMS);
	assign last_idx    = IDX_W'(cnt_q - CNT_W'(1));
	assign final_round = rounds_q == (cnt_q - CNT_W'(1));
	// count mode keeps while below capacity, weight mode rejects only above it
	assign accept      = (mode == MODE_COUNT) ? alu_rsp.hit : !alu_rsp.hit;
	assign better      = (state_q == ST_SCAN) && rd_valid_s1 && !taken_q[rd_idx_s1] &&
	                     (!found_q || alu_rsp.hit);

	assign mem_waddr = cnt_q[IDX_W-1:0];
	assign mem_wdata = item.weight;
	assign mem_raddr = issue_cnt_q[IDX_W-1:0];

	// one unit: scan compares fetched vs best, test adds and compares to the limit
	always_comb begin
		alu_req.op = (mode == MODE_WEIGHT) ? CMP_GREATER : CMP_LESS;
		if (state_q == ST_TEST) begin
			alu_req.add_en = 1'b1;
			alu_req.x      = SUM_W'(best_q);
			alu_req.s      = sum_q;
			alu_req.r      = SUM_W'({capacity, {FRAC_W{1'b0}}});
		end else begin
			alu_req.add_en = 1'b0;
			alu_req.x      = SUM_W'(mem_rdata);
			alu_req.s      = sum_q;
			alu_req.r      = SUM_W'(best_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					mem_we = store_room;
					if (item.last_item) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				mem_re = issue_cnt_q < cnt_q;
				if (rd_valid_s1 && (rd_idx_s1 == last_idx)) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (!accept && (mode == MODE_COUNT)) begin
					state_d = ST_FINISH;
				end else if (final_round) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			issue_cnt_q <= '0;
			rounds_q    <= '0;
			sum_q       <= '0;
			taken_q     <= '0;
			found_q     <= 1'b0;
			have_pend_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					issue_cnt_q <= '0;
					rounds_q    <= '0;
					found_q     <= 1'b0;
					if (start && store_room) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
					if (better) begin
						found_q <= 1'b1;
					end
				end
				ST_TEST: begin
					taken_q[best_idx_q] <= 1'b1;
					rounds_q            <= rounds_q + CNT_W'(1);
					issue_cnt_q         <= '0;
					found_q             <= 1'b0;
					if (accept) begin
						sum_q       <= alu_rsp.sum;
						have_pend_q <= 1'b1;
						// the previous pick is now known not to be the last
						res_valid_q <= have_pend_q;
					end
				end
				ST_FINISH: begin
					cnt_q       <= '0;
					sum_q       <= '0;
					taken_q     <= '0;
					have_pend_q <= 1'b0;
					res_valid_q <= 1'b1;
				end
				default: begin
					res_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= mem_raddr;
		if (better) begin
			best_q     <= mem_rdata;
			best_idx_q <= rd_idx_s1;
		end
		if ((state_q == ST_TEST) && accept) begin
			pend_q <= best_q;
			res_q  <= '{chosen_weight: pend_q, end_of_run: 1'b0, none_chosen: 1'b0};
		end
		if (state_q == ST_FINISH) begin
			if (have_pend_q) begin
				res_q <= '{chosen_weight: pend_q, end_of_run: 1'b1, none_chosen: 1'b0};
			end else begin
				res_q <= '{chosen_weight: '0, end_of_run: 1'b1, none_chosen: 1'b1};
			end
		end
	end

	assign result       = res_q;
	assign result_valid = res_valid_q;

	`GCL_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_ITEMS), "item count above store depth")
	`GCL_ASSERT_IMP(a_rd_in_scan, rd_valid_s1, state_q == ST_SCAN, "read data outside a scan")
	`GCL_ASSERT_IMP(a_empty_is_end, result_valid && result.none_chosen, result.end_of_run,
		"empty result not marked as end")
	`GCL_ASSERT_NXT(a_finish_clears, state_q == ST_FINISH, cnt_q == '0 && sum_q == '0,
		"set not cleared after selection")
	`GCL_ASSERT_IMP(a_res_source, result_valid,
		$past(state_q == ST_TEST) || $past(state_q == ST_FINISH), "result outside selection")

endmodule
